// File: rtl/core/rtri_pkg.sv
// ----------------------------------------------------------------------------
// rtri_pkg
// Shared constants and types for the RSSI trilateration block.
// ----------------------------------------------------------------------------
package rtri_pkg;

  localparam int RssiRefDefault = -45;
  localparam int Log2TenQ16     = 217706;
  localparam int RawCap         = 131072;
  localparam int CollinearLimit = 1000;

  localparam logic [2:0] REG_A0X = 3'd0;
  localparam logic [2:0] REG_A0Y = 3'd1;
  localparam logic [2:0] REG_A1X = 3'd2;
  localparam logic [2:0] REG_A1Y = 3'd3;
  localparam logic [2:0] REG_A2X = 3'd4;
  localparam logic [2:0] REG_A2Y = 3'd5;
  localparam logic [2:0] REG_HGT = 3'd6;
  localparam logic [2:0] REG_EXP = 3'd7;

  localparam logic [1:0] FIX_VALID     = 2'd0;
  localparam logic [1:0] FIX_COLLINEAR = 2'd1;
  localparam logic [1:0] FIX_SATURATED = 2'd2;

  // Anchor geometry handed to the solver.
  typedef struct packed {
    logic signed [15:0] x0;
    logic signed [15:0] y0;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic signed [15:0] x2;
    logic signed [15:0] y2;
  } anchors_t;

endpackage

// File: rtl/core/rtri_lane.sv
// ----------------------------------------------------------------------------
// rtri_lane
// One ranging lane: RSSI to height-compensated range, fully pipelined.
// ----------------------------------------------------------------------------
module rtri_lane #(
  parameter int RssiRef = rtri_pkg::RssiRefDefault
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [7:0]  rssi,
  input  logic [10:0]        loss_exponent,
  input  logic signed [14:0] height_offset,
  output logic [15:0]        range
);

  // Stage 1: numerator times log2(10), the divisor and the squared height offset.
  logic signed [9:0]  diff;
  logic signed [35:0] num1;
  logic [14:0]        den1;
  logic [29:0]        hh1;
  assign diff = 10'(RssiRef) - 10'(rssi);
  always_ff @(posedge clk) begin
    if (en) begin
      num1 <= 36'(diff) * 36'(rtri_pkg::Log2TenQ16 * 256);
      den1 <= 15'(loss_exponent == 11'd0 ? 11'd1 : loss_exponent) * 15'd10;
      hh1  <= 30'(height_offset * height_offset);
    end
  end

  // Floor division of a signed numerator by a positive divisor, one
  // quotient bit per step on the magnitude.
  // Four bits per registered stage keeps each stage short.
  logic [35:0] rg_rem [0:9];
  logic [35:0] rg_quo [0:9];
  logic [35:0] rg_mag [0:9];
  logic        rg_neg [0:9];
  logic [14:0] rg_dd  [0:9];
  logic [29:0] rg_hh  [0:9];
  always_comb begin
    rg_rem[0] = '0; rg_quo[0] = '0;
    rg_mag[0] = num1[35] ? 36'(-num1) : 36'(num1);
    rg_neg[0] = num1[35]; rg_dd[0] = den1; rg_hh[0] = hh1;
  end
  genvar g;
  generate
    for (g = 0; g < 9; g++) begin : g_div
      logic [35:0] r_c [0:4];
      logic [35:0] q_c [0:4];
      logic [36:0] t;
      always_comb begin
        r_c[0] = rg_rem[g];
        q_c[0] = rg_quo[g];
        for (int b = 0; b < 4; b++) begin
          t = {r_c[b], rg_mag[g][35 - (g * 4 + b)]};
          if (t >= 37'(rg_dd[g])) begin
            r_c[b + 1] = 36'(t - 37'(rg_dd[g]));
            q_c[b + 1] = {q_c[b][34:0], 1'b1};
          end else begin
            r_c[b + 1] = t[35:0];
            q_c[b + 1] = {q_c[b][34:0], 1'b0};
          end
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rg_rem[g + 1] <= r_c[4];
          rg_quo[g + 1] <= q_c[4];
          rg_mag[g + 1] <= rg_mag[g];
          rg_neg[g + 1] <= rg_neg[g];
          rg_dd[g + 1]  <= rg_dd[g];
          rg_hh[g + 1]  <= rg_hh[g];
        end
      end
    end
  endgenerate

  // Floor of the signed quotient.
  logic signed [36:0] y;
  logic [29:0]        hh2;
  always_ff @(posedge clk) begin
    if (en) begin
      if (rg_neg[9])
        y <= -$signed({1'b0, rg_quo[9]}) - ((rg_rem[9] != '0) ? 37'sd1 : 37'sd0);
      else
        y <= $signed({1'b0, rg_quo[9]});
      hh2 <= rg_hh[9];
    end
  end

  // Exponent split and three Horner steps, at most one multiply per stage.
  logic signed [20:0] k3, k4, k5, k6;
  logic [15:0]        f3, f4, f5;
  logic [16:0]        p3, p4, p5;
  logic [29:0]        hh3, hh4, hh5, hh6;
  logic [16:0]        m6;
  always_ff @(posedge clk) begin
    if (en) begin
      k3 <= y[36:16];
      f3 <= y[15:0];
      hh3 <= hh2;
      p3 <= 17'(14816 + ((32'd5118 * 32'(y[15:0])) >> 16));
      k4 <= k3; f4 <= f3; hh4 <= hh3;
      p4 <= 17'(45602 + ((33'(p3) * 33'(f3)) >> 16));
      k5 <= k4; f5 <= f4; hh5 <= hh4;
      p5 <= p4;
      k6 <= k5; hh6 <= hh5;
      m6 <= 17'(65536 + ((33'(p5) * 33'(f5)) >> 16));
    end
  end

  // Scale by 1000 and shift by k-16, rounding half up, capped.
  logic [26:0] v7;
  logic signed [20:0] k7;
  logic [29:0] hh7;
  logic [17:0] raw8;
  logic [29:0] hh8;
  logic [63:0] sh_w;
  always_ff @(posedge clk) begin
    if (en) begin
      v7 <= 27'(m6) * 27'd1000;
      k7 <= k6; hh7 <= hh6;
    end
  end
  always_comb begin
    sh_w = '0;
    if (k7 > 21'sd20) sh_w = 64'(rtri_pkg::RawCap);
    else if (k7 < -21'sd40) sh_w = '0;
    else if (k7 >= 21'sd16) sh_w = 64'(v7) << (k7 - 21'sd16);
    else sh_w = (64'(v7) + (64'd1 << (6'(21'sd15 - k7)))) >> (6'(21'sd16 - k7));
    if (sh_w > 64'(rtri_pkg::RawCap)) sh_w = 64'(rtri_pkg::RawCap);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      raw8 <= sh_w[17:0];
      hh8  <= hh7;
    end
  end

  // Square difference, floored at zero.
  logic [35:0] rr9;
  logic [29:0] hh9;
  always_ff @(posedge clk) begin
    if (en) begin
      rr9 <= 36'(raw8) * 36'(raw8);
      hh9 <= hh8;
    end
  end
  logic [35:0] r2c;
  assign r2c = (rr9 > 36'(hh9)) ? rr9 - 36'(hh9) : '0;

  // Integer square root, two result bits per stage.
  logic [35:0] sx [0:9];
  logic [35:0] sr [0:9];
  always_ff @(posedge clk) begin
    if (en) begin
      sx[0] <= r2c;
      sr[0] <= '0;
    end
  end
  generate
    for (g = 0; g < 9; g++) begin : g_sqrt
      logic [35:0] xa, ra, xb, rb, b0, b1;
      always_comb begin
        b0 = 36'd1 << (34 - 4 * g);
        b1 = 36'd1 << (32 - 4 * g);
        if (sx[g] >= sr[g] + b0) begin
          xa = sx[g] - (sr[g] + b0); ra = (sr[g] >> 1) + b0;
        end else begin
          xa = sx[g]; ra = sr[g] >> 1;
        end
        if (xa >= ra + b1) begin
          xb = xa - (ra + b1); rb = (ra >> 1) + b1;
        end else begin
          xb = xa; rb = ra >> 1;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          sx[g + 1] <= xb;
          sr[g + 1] <= rb;
        end
      end
    end
  endgenerate

  assign range = (sr[9] > 36'd65535) ? 16'hFFFF : sr[9][15:0];

endmodule

// File: rtl/core/rtri_solve.sv
// ----------------------------------------------------------------------------
// rtri_solve
// Merges the three lane ranges: linearised trilateration and rounding divide.
// ----------------------------------------------------------------------------
module rtri_solve (
  input  logic              clk,
  input  logic              en,
  input  rtri_pkg::anchors_t anc,
  input  logic [15:0]       r0,
  input  logic [15:0]       r1,
  input  logic [15:0]       r2,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic [1:0]        fix_status
);

  localparam int DivBits = 68;
  localparam int PerStg  = 4;
  localparam int NStg    = DivBits / PerStg;

  // Stage A: squares and anchor differences.
  logic signed [35:0] a1, b1, a2, b2;
  logic signed [35:0] r0s, r1s, r2s, k0, k1, k2;
  always_ff @(posedge clk) begin
    if (en) begin
      a1  <= 36'(2 * (anc.x1 - anc.x0));
      b1  <= 36'(2 * (anc.y1 - anc.y0));
      a2  <= 36'(2 * (anc.x2 - anc.x0));
      b2  <= 36'(2 * (anc.y2 - anc.y0));
      r0s <= $signed({4'd0, 32'(r0) * 32'(r0)});
      r1s <= $signed({4'd0, 32'(r1) * 32'(r1)});
      r2s <= $signed({4'd0, 32'(r2) * 32'(r2)});
      k0  <= 36'(anc.x0 * anc.x0) + 36'(anc.y0 * anc.y0);
      k1  <= 36'(anc.x1 * anc.x1) + 36'(anc.y1 * anc.y1);
      k2  <= 36'(anc.x2 * anc.x2) + 36'(anc.y2 * anc.y2);
    end
  end

  // Stage B: right-hand sides.
  logic signed [35:0] a1b, b1b, a2b, b2b, c1, c2;
  always_ff @(posedge clk) begin
    if (en) begin
      a1b <= a1; b1b <= b1; a2b <= a2; b2b <= b2;
      c1 <= r0s - r1s - k0 + k1;
      c2 <= r0s - r2s - k0 + k2;
    end
  end

  // Stage C: cross products.
  logic signed [71:0] p1, p2, p3, p4, p5, p6;
  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= 72'(c1 * b2b); p2 <= 72'(c2 * b1b);
      p3 <= 72'(a1b * c2); p4 <= 72'(a2b * c1);
      p5 <= 72'(a1b * b2b); p6 <= 72'(b1b * a2b);
    end
  end

  // Stage D: numerators, determinant and magnitudes.
  logic signed [71:0] nx, ny, dt;
  always_comb begin
    nx = p1 - p2;
    ny = p3 - p4;
    dt = p5 - p6;
  end
  logic [67:0] mx, my, md;
  logic        sx_d, sy_d, coll;
  always_ff @(posedge clk) begin
    if (en) begin
      mx   <= 68'(nx[71] ? -nx : nx);
      my   <= 68'(ny[71] ? -ny : ny);
      md   <= 68'(dt[71] ? -dt : dt);
      sx_d <= nx[71] ^ dt[71];
      sy_d <= ny[71] ^ dt[71];
      coll <= (dt > -72'sd1000) && (dt < 72'(rtri_pkg::CollinearLimit));
    end
  end

  // Rounded magnitudes: add half the divisor, then divide.
  logic [67:0] dq_x [0:NStg], dq_y [0:NStg], dr_x [0:NStg], dr_y [0:NStg];
  logic [67:0] dn_x [0:NStg], dn_y [0:NStg], dv [0:NStg];
  logic        sg_x [0:NStg], sg_y [0:NStg], cl [0:NStg];
  always_ff @(posedge clk) begin
    if (en) begin
      dn_x[0] <= mx + (md >> 1);
      dn_y[0] <= my + (md >> 1);
      dv[0] <= (md == '0) ? 68'd1 : md;
      dq_x[0] <= '0; dq_y[0] <= '0; dr_x[0] <= '0; dr_y[0] <= '0;
      sg_x[0] <= sx_d; sg_y[0] <= sy_d; cl[0] <= coll;
    end
  end
  genvar g;
  generate
    for (g = 0; g < NStg; g++) begin : g_div
      logic [67:0] rx [0:PerStg], qx [0:PerStg], ry [0:PerStg], qy [0:PerStg];
      logic [68:0] tx, ty;
      always_comb begin
        rx[0] = dr_x[g]; qx[0] = dq_x[g]; ry[0] = dr_y[g]; qy[0] = dq_y[g];
        for (int b = 0; b < PerStg; b++) begin
          tx = {rx[b], dn_x[g][DivBits - 1 - (g * PerStg + b)]};
          ty = {ry[b], dn_y[g][DivBits - 1 - (g * PerStg + b)]};
          if (tx >= 69'(dv[g])) begin
            rx[b + 1] = 68'(tx - 69'(dv[g])); qx[b + 1] = {qx[b][66:0], 1'b1};
          end else begin
            rx[b + 1] = tx[67:0]; qx[b + 1] = {qx[b][66:0], 1'b0};
          end
          if (ty >= 69'(dv[g])) begin
            ry[b + 1] = 68'(ty - 69'(dv[g])); qy[b + 1] = {qy[b][66:0], 1'b1};
          end else begin
            ry[b + 1] = ty[67:0]; qy[b + 1] = {qy[b][66:0], 1'b0};
          end
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          dr_x[g + 1] <= rx[PerStg]; dq_x[g + 1] <= qx[PerStg];
          dr_y[g + 1] <= ry[PerStg]; dq_y[g + 1] <= qy[PerStg];
          dn_x[g + 1] <= dn_x[g]; dn_y[g + 1] <= dn_y[g]; dv[g + 1] <= dv[g];
          sg_x[g + 1] <= sg_x[g]; sg_y[g + 1] <= sg_y[g]; cl[g + 1] <= cl[g];
        end
      end
    end
  endgenerate

  // Sign, clamp and status.
  logic signed [15:0] cx, cy;
  logic               satx, saty;
  always_comb begin
    satx = 1'b0; saty = 1'b0;
    if (sg_x[NStg] && dq_x[NStg] > 68'd32768) begin
      cx = -16'sd32768; satx = 1'b1;
    end else if (!sg_x[NStg] && dq_x[NStg] > 68'd32767) begin
      cx = 16'sd32767; satx = 1'b1;
    end else begin
      cx = sg_x[NStg] ? -$signed(dq_x[NStg][15:0]) : $signed(dq_x[NStg][15:0]);
    end
    if (sg_y[NStg] && dq_y[NStg] > 68'd32768) begin
      cy = -16'sd32768; saty = 1'b1;
    end else if (!sg_y[NStg] && dq_y[NStg] > 68'd32767) begin
      cy = 16'sd32767; saty = 1'b1;
    end else begin
      cy = sg_y[NStg] ? -$signed(dq_y[NStg][15:0]) : $signed(dq_y[NStg][15:0]);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (cl[NStg]) begin
        pos_x <= '0; pos_y <= '0; fix_status <= rtri_pkg::FIX_COLLINEAR;
      end else begin
        pos_x <= cx; pos_y <= cy;
        fix_status <= (satx || saty) ? rtri_pkg::FIX_SATURATED : rtri_pkg::FIX_VALID;
      end
    end
  end

endmodule

// File: rtl/core/rssi_trilateration_2d.sv
// ----------------------------------------------------------------------------
// rssi_trilateration_2d
// Three-beacon RSSI ranging and planar trilateration.
// ----------------------------------------------------------------------------
// Accepts one word of three RSSI readings per cycle while the output is not
// stalled and returns one result word per input, in order, through 28 stages in each
// ranging lane and 23 in the solver. Three ranging lanes work in parallel; the
// pipeline depth is set by the restoring dividers (exponent divide in each lane,
// position divide in the solver) and the root stages. The whole pipeline
// advances only when the output stage can take a word, so a stall on the
// output side holds every stage. Write the registers only while idle.
// ----------------------------------------------------------------------------
module rssi_trilateration_2d #(
  parameter int RssiRef = rtri_pkg::RssiRefDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // rssi_first, rssi_second, rssi_third
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // range_first, range_second, range_third,
                                 // pos_x, pos_y, fix_status, zero fill
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Pipeline depths of a ranging lane and of the solver.
  localparam int LaneLat  = 28;
  localparam int SolveLat = 1 + 1 + 1 + 1 + 1 + 17 + 1;
  localparam int Latency  = LaneLat + SolveLat;

  // Configuration registers.
  rtri_pkg::anchors_t anc;
  logic signed [14:0] height_offset;
  logic [10:0]        loss_exponent;
  always_ff @(posedge clk) begin
    if (rst) begin
      anc <= '{x0: 16'sd0, y0: 16'sd0, x1: 16'sd0, y1: 16'sd8800,
               x2: 16'sd3300, y2: 16'sd8800};
      height_offset <= 15'sd800;
      loss_exponent <= 11'd640;
    end else if (cfg_we) begin
      case (cfg_index)
        rtri_pkg::REG_A0X: anc.x0 <= cfg_data;
        rtri_pkg::REG_A0Y: anc.y0 <= cfg_data;
        rtri_pkg::REG_A1X: anc.x1 <= cfg_data;
        rtri_pkg::REG_A1Y: anc.y1 <= cfg_data;
        rtri_pkg::REG_A2X: anc.x2 <= cfg_data;
        rtri_pkg::REG_A2Y: anc.y2 <= cfg_data;
        rtri_pkg::REG_HGT: height_offset <= cfg_data[14:0];
        rtri_pkg::REG_EXP: loss_exponent <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Global stall: everything moves when the output slot is free or taken.
  logic en;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  logic [Latency-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Latency-2:0], s_tvalid};
  end
  assign m_tvalid = vld[Latency-1];

  // Ranging lanes.
  logic [15:0] rng [0:2];
  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_lane
      rtri_lane #(.RssiRef(RssiRef)) u_lane (
        .clk(clk), .en(en), .rssi(s_tdata[g*8 +: 8]),
        .loss_exponent(loss_exponent), .height_offset(height_offset),
        .range(rng[g]));
    end
  endgenerate

  // Delay ranges to line up with the solver output.
  logic [47:0] rd [0:SolveLat-1];
  always_ff @(posedge clk) begin
    if (en) begin
      rd[0] <= {rng[2], rng[1], rng[0]};
      for (int i = 1; i < SolveLat; i++) rd[i] <= rd[i - 1];
    end
  end

  logic signed [15:0] pos_x, pos_y;
  logic [1:0]         fix_status;
  rtri_solve u_solve (
    .clk(clk), .en(en), .anc(anc), .r0(rng[0]), .r1(rng[1]), .r2(rng[2]),
    .pos_x(pos_x), .pos_y(pos_y), .fix_status(fix_status));

  assign m_tdata = {6'd0, fix_status, pos_y, pos_x, rd[SolveLat-1]};

  // The pipeline never accepts while the output is blocked.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input accepted during output stall");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result lost during stall");
  a_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && fix_status == rtri_pkg::FIX_COLLINEAR) |-> (pos_x == 16'sd0 && pos_y == 16'sd0))
    else $error("collinear result with nonzero position");

endmodule
